FILE: src/brsc_pkg.sv
package brsc_pkg;

    // map geometry
    localparam int MAP_BITS   = 1024;
    localparam int WORD_BITS  = 64;
    localparam int NUM_WORDS  = MAP_BITS / WORD_BITS;
    localparam int WORD_IDX_W = $clog2(NUM_WORDS);
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);

    // field widths
    localparam int KIND_W = 2;
    localparam int POS_W  = 10;
    localparam int LEN_W  = 11;
    localparam int CFG_W  = 11;

    // configuration port
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] CFG_IDX_BITS_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0]   BITS_IN_USE_RESET   = 11'd1024;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIND  = 2'd2;

    localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  start_bit;
        logic [LEN_W-1:0]  run_length;
    } req_word_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } rsp_word_t;

    typedef struct packed {
        logic                  en;
        logic [WORD_IDX_W-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        logic                  en;
        logic [WORD_IDX_W-1:0] addr;
        logic [WORD_BITS-1:0]  data;
    } mem_wr_t;

    typedef struct packed {
        logic      done;
        rsp_word_t word;
    } seq_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } seq_state_t;

endpackage

FILE: src/brsc_mem.sv
module brsc_mem
    import brsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mem_rd_t              rd,
    input  mem_wr_t              wr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] valid_reg;
    logic [WORD_BITS-1:0] rd_word_reg;
    logic                 rd_hit_reg;

    // per-entry written flags, cleared at reset so the map reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_word_reg <= mem[rd.addr];
            rd_hit_reg  <= valid_reg[rd.addr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : '0;

`ifndef NO_ASSERTIONS
    // a written entry stays marked
    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> valid_reg[$past(wr.addr)])
        else $error("written entry lost its valid flag");
`endif

endmodule

FILE: src/brsc_seq.sv
module brsc_seq
    import brsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_take,
    input  req_word_t            req,
    input  logic [CFG_W-1:0]     bits_in_use,
    input  logic                 slot_free,
    input  logic [WORD_BITS-1:0] rd_data,
    output logic                 busy,
    output seq_res_t             res,
    output mem_rd_t              mem_rd,
    output mem_wr_t              mem_wr
);

    seq_state_t            state_reg, state_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [POS_W-1:0]      start_reg, start_next;
    logic [POS_W-1:0]      last_reg, last_next;
    logic [WORD_IDX_W-1:0] word_reg, word_next;
    logic                  found_reg, found_next;
    logic [POS_W-1:0]      pos_reg, pos_next;

    logic [LEN_W:0]         run_end;
    logic [LEN_W-1:0]       run_end_clip;
    logic [CFG_W-1:0]       limit;
    logic                   run_ok;
    logic                   find_ok;
    logic [WORD_BITS-1:0]   lo_mask;
    logic [WORD_BITS-1:0]   hi_mask;
    logic [WORD_BITS-1:0]   span;
    logic [WORD_BITS-1:0]   cand;
    logic [BIT_IDX_W-1:0]   low_idx;
    logic                   is_last;
    logic                   is_find;

    // request decode: clipped run end and search limit
    always_comb
    begin
        run_end      = {2'b00, req.start_bit} + {1'b0, req.run_length};
        run_end_clip = (run_end > (LEN_W+1)'(MAP_BITS)) ? LEN_W'(MAP_BITS)
                                                        : run_end[LEN_W-1:0];
        limit        = bits_in_use[CFG_W-1] ? CFG_W'(MAP_BITS) : bits_in_use;
        run_ok       = (req.run_length != '0);
        find_ok      = (limit != '0) && ({1'b0, req.start_bit} < limit);
    end

    // masks for the word being processed
    always_comb
    begin
        is_last = (word_reg == last_reg[POS_W-1 -: WORD_IDX_W]);
        lo_mask = (word_reg == start_reg[POS_W-1 -: WORD_IDX_W])
                  ? (ALL_ONES << start_reg[BIT_IDX_W-1:0]) : ALL_ONES;
        hi_mask = is_last
                  ? (ALL_ONES >> (BIT_IDX_W'(WORD_BITS - 1) - last_reg[BIT_IDX_W-1:0]))
                  : ALL_ONES;
        span    = lo_mask & hi_mask;
        cand    = ~rd_data & span;
        is_find = (kind_reg == KIND_FIND);
    end

    // lowest zero bit of the candidate word
    always_comb
    begin
        low_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                low_idx = BIT_IDX_W'(i);
            end
        end
    end

    // state and request registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        start_reg <= start_next;
        last_reg  <= last_next;
        word_reg  <= word_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
    end

    // sequencer: read a word, update or search it, write back (set and clear only), move on
    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        start_next  = start_reg;
        last_next   = last_reg;
        word_next   = word_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;
        mem_rd      = '0;
        mem_wr      = '0;
        busy        = 1'b1;
        res         = '0;
        res.word    = '{found: found_reg, position: pos_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (req_take)
                begin
                    kind_next  = req.kind;
                    start_next = req.start_bit;
                    word_next  = req.start_bit[POS_W-1 -: WORD_IDX_W];
                    found_next = 1'b0;
                    pos_next   = '0;
                    mem_rd.addr = req.start_bit[POS_W-1 -: WORD_IDX_W];
                    unique case (req.kind) inside
                        KIND_SET, KIND_CLEAR:
                        begin
                            last_next  = POS_W'(run_end_clip - LEN_W'(1));
                            mem_rd.en  = run_ok;
                            state_next = run_ok ? ST_SCAN : ST_FINISH;
                        end
                        KIND_FIND:
                        begin
                            last_next  = POS_W'(limit - CFG_W'(1));
                            mem_rd.en  = find_ok;
                            state_next = find_ok ? ST_SCAN : ST_FINISH;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (is_find)
                begin
                    if (cand != '0)
                    begin
                        found_next = 1'b1;
                        pos_next   = {word_reg, low_idx};
                        state_next = ST_FINISH;
                    end
                    else if (is_last)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        mem_rd.en   = 1'b1;
                        mem_rd.addr = word_reg + WORD_IDX_W'(1);
                        word_next   = word_reg + WORD_IDX_W'(1);
                    end
                end
                else
                begin
                    mem_wr.en   = 1'b1;
                    mem_wr.addr = word_reg;
                    mem_wr.data = (kind_reg == KIND_SET) ? (rd_data | span)
                                                         : (rd_data & ~span);
                    if (is_last)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        mem_rd.en   = 1'b1;
                        mem_rd.addr = word_reg + WORD_IDX_W'(1);
                        word_next   = word_reg + WORD_IDX_W'(1);
                    end
                end
            end

            ST_FINISH:
            begin
                res.done = 1'b1;
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // the walk never passes the last word of the run or search
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (word_reg <= last_reg[POS_W-1 -: WORD_IDX_W]))
        else $error("word walk passed its last word");

    // read and write-back never hit the same word in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_rd.en && mem_wr.en) |-> (mem_rd.addr != mem_wr.addr))
        else $error("read and write to the same word");

    // a delivered result frees the sequencer
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res.done && slot_free) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle");

    // set and clear never report a hit
    a_no_hit_on_run: assert property (@(posedge clk) disable iff (!rst_n)
        (res.done && (kind_reg != KIND_FIND)) |-> !res.word.found)
        else $error("run request reported a found bit");
`endif

endmodule

FILE: src/bitmap_range_set_clear_find_zero.sv
// channel  direction  word                                  handshake
// req      in         kind, start_bit, run_length            req_valid / req_stall
// rsp      out        found, position                        rsp_valid / rsp_stall
// cfg      in         bits_in_use at byte address 0          APB, pready tied high
//
// an item walks the map words of its run or search (1 to 16), or none when
// there is nothing to walk; the single read port of the word memory
// paces the walk at one word per cycle
// req_stall is high while an item is in work; the result waits in the output
// register, so the next item may start while rsp_stall holds it
// reset clears the map and loads bits_in_use with 1024
module bitmap_range_set_clear_find_zero
    import brsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_word_t          req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_word_t          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [CFG_W-1:0]     bits_in_use_reg;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_word_t            rsp_reg;
    logic                 busy;
    logic                 req_take;
    logic                 slot_free;
    logic                 cfg_write;
    logic                 cfg_hit;
    seq_res_t             res;
    mem_rd_t              mem_rd;
    mem_wr_t              mem_wr;
    logic [WORD_BITS-1:0] rd_data;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[PADDR_W-1:2] == CFG_IDX_BITS_IN_USE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = cfg_hit ? DATA_W'(bits_in_use_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_in_use_reg <= BITS_IN_USE_RESET;
        end
        else if (cfg_write && cfg_hit)
        begin
            bits_in_use_reg <= pwdata[CFG_W-1:0];
        end
    end

    // input handshake
    assign req_stall = busy;
    assign req_take  = req_valid && !busy;

    // output register
    assign slot_free      = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid_next = res.done ? 1'b1 : (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.done && slot_free)
        begin
            rsp_reg <= res.word;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    brsc_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_take    (req_take),
        .req         (req),
        .bits_in_use (bits_in_use_reg),
        .slot_free   (slot_free),
        .rd_data     (rd_data),
        .busy        (busy),
        .res         (res),
        .mem_rd      (mem_rd),
        .mem_wr      (mem_wr)
    );

    brsc_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (mem_rd),
        .wr      (mem_wr),
        .rd_data (rd_data)
    );

`ifndef NO_ASSERTIONS
    // an accepted item holds off the next one
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("input not stalled after accepting an item");

    // a finished result is never dropped by the output register
    a_res_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (res.done && slot_free) |=> rsp_valid)
        else $error("finished result not presented");

    // the memory is never written between items
    a_mem_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy) |-> !mem_wr.en)
        else $error("memory write while idle");
`endif

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import brsc_pkg::*;

    localparam int TIMEOUT_NS   = 20_000_000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 240;
    localparam int NUM_PHASES   = 7;

    // kind value with no operation behind it
    localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;
    localparam logic [PADDR_W-1:0] LIMIT_ADDR  = {CFG_IDX_BITS_IN_USE, 2'b00};
    localparam logic [PADDR_W-1:0] SPARE_ADDR  = 3'd4;

    typedef enum int {
        IDLE_NONE,
        IDLE_SOME,
        IDLE_FULL
    } idle_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic req_valid = 1'b0;
    logic req_stall;
    req_word_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_word_t rsp;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    // shadow of the block: map contents and search limit
    bit [MAP_BITS-1:0] map_shadow;
    logic [CFG_W-1:0] limit_shadow;

    req_word_t pending_req_q[$];
    rsp_word_t predicted_rsp_q[$];
    rsp_word_t got_rsp;

    int items_queued = 0;
    int items_accepted = 0;
    int fail_count = 0;
    int send_gap = 0;
    int recv_wait = 0;
    int recv_draw;
    int hold_left = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    idle_mode_t send_mode = IDLE_NONE;
    idle_mode_t recv_mode = IDLE_NONE;

    int n_set = 0;
    int n_clear = 0;
    int n_find = 0;
    int n_unused = 0;
    int n_hit = 0;
    int n_limits = 0;

    bitmap_range_set_clear_find_zero dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #10 clk = ~clk;

    // apply one request to the shadow map and work out its answer
    function automatic rsp_word_t bitmap_apply(req_word_t r);
        rsp_word_t res;
        int stop;
        int limit;
        int p;
        res = '0;
        case (r.kind) inside
            KIND_SET, KIND_CLEAR:
            begin
                stop = int'(r.start_bit) + int'(r.run_length);
                if (stop > MAP_BITS)
                    stop = MAP_BITS;
                for (p = int'(r.start_bit); p < stop; p++)
                    map_shadow[p] = (r.kind == KIND_SET);
            end
            KIND_FIND:
            begin
                limit = (int'(limit_shadow) < MAP_BITS) ? int'(limit_shadow) : MAP_BITS;
                for (p = int'(r.start_bit); p < limit && !res.found; p++)
                begin
                    if (!map_shadow[p])
                    begin
                        res.found = 1'b1;
                        res.position = p[POS_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic int draw_gap(idle_mode_t mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 15)) : 0;
            default:   return int'($urandom_range(0, 15));
        endcase
    endfunction

    // random request: mostly short runs, searches often inside the limit
    function automatic req_word_t random_req();
        req_word_t r;
        int sel;
        int lim;
        sel = int'($urandom_range(0, 99));
        if (sel < 30)
            r.kind = KIND_SET;
        else if (sel < 60)
            r.kind = KIND_CLEAR;
        else if (sel < 95)
            r.kind = KIND_FIND;
        else
            r.kind = KIND_UNUSED;
        r.start_bit = POS_W'($urandom_range(0, MAP_BITS - 1));
        sel = int'($urandom_range(0, 9));
        if (sel < 7)
            r.run_length = LEN_W'($urandom_range(0, 80));
        else if (sel < 9)
            r.run_length = LEN_W'($urandom_range(0, MAP_BITS));
        else
            r.run_length = LEN_W'($urandom_range(0, 2047));
        lim = (int'(limit_shadow) < MAP_BITS) ? int'(limit_shadow) : MAP_BITS;
        if (r.kind == KIND_FIND && lim > 0 && $urandom_range(0, 1) == 1)
            r.start_bit = POS_W'($urandom_range(0, lim - 1));
        return r;
    endfunction

    task automatic queue_req(logic [KIND_W-1:0] kind, int start, int len);
        req_word_t r;
        r.kind = kind;
        r.start_bit = POS_W'(start);
        r.run_length = LEN_W'(len);
        pending_req_q.push_back(r);
        items_queued++;
    endtask

    // wait for every queued word to be answered, then let the block settle
    task automatic drain();
        while (items_accepted != items_queued || predicted_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [PADDR_W-1:0] addr, logic [CFG_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {(DATA_W - CFG_W)'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == LIMIT_ADDR)
        begin
            limit_shadow = value;
            n_limits++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic cfg_check(logic [PADDR_W-1:0] addr);
        logic [DATA_W-1:0] want;
        want = {{(DATA_W - CFG_W){1'b0}}, limit_shadow};
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $error("prdata: expected %0d, got %0d", want, prdata);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // request driver: words come from the pending queue, gaps drawn per word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                predicted_rsp_q.push_back(bitmap_apply(req));
                case (req.kind)
                    KIND_SET:   n_set++;
                    KIND_CLEAR: n_clear++;
                    KIND_FIND:  n_find++;
                    default:    n_unused++;
                endcase
                items_accepted++;
            end
            if (!req_valid || !req_stall)
            begin
                if (send_gap > 0)
                begin
                    req_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_req_q.size() > 0)
                begin
                    req <= pending_req_q.pop_front();
                    req_valid <= 1'b1;
                    send_gap <= draw_gap(send_mode);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // response side stall: per-word waits plus an occasional long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            recv_wait <= 0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= LONG_HOLD;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= (hold_left > 1);
        end
        else if (rsp_valid && !rsp_stall)
        begin
            recv_draw = draw_gap(recv_mode);
            recv_wait <= recv_draw;
            rsp_stall <= (recv_draw > 0);
        end
        else if (recv_wait > 0)
        begin
            recv_wait <= recv_wait - 1;
            rsp_stall <= (recv_wait > 1);
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    // response monitor: compare each word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (predicted_rsp_q.size() == 0)
            begin
                $error("unexpected result word: found %0d, position %0d",
                       rsp.found, rsp.position);
                fail_count++;
            end
            else
            begin
                got_rsp = predicted_rsp_q.pop_front();
                if (rsp.found !== got_rsp.found)
                begin
                    $error("found: expected %0d, got %0d", got_rsp.found, rsp.found);
                    fail_count++;
                end
                if (rsp.position !== got_rsp.position)
                begin
                    $error("position: expected %0d, got %0d",
                           got_rsp.position, rsp.position);
                    fail_count++;
                end
                if (got_rsp.found)
                    n_hit++;
            end
        end
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] phase_limit [NUM_PHASES];
        int ph;
        int i;
        phase_limit = '{11'd1024, 11'd1, 11'd2047, 11'd0, 11'd700, 11'd64, 11'd0};
        phase_limit[NUM_PHASES - 1] = CFG_W'($urandom_range(1, MAP_BITS));
        map_shadow = '0;
        limit_shadow = BITS_IN_USE_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cfg_check(LIMIT_ADDR);

        // directed: empty map, full runs, clipping, word edges, unused kind
        send_mode = IDLE_SOME;
        recv_mode = IDLE_SOME;
        queue_req(KIND_FIND, 0, 0);
        queue_req(KIND_FIND, MAP_BITS - 1, 2047);
        queue_req(KIND_SET, 0, MAP_BITS);
        queue_req(KIND_FIND, 0, 0);
        queue_req(KIND_CLEAR, MAP_BITS - 1, MAP_BITS);
        queue_req(KIND_FIND, 0, 0);
        queue_req(KIND_CLEAR, 0, 0);
        queue_req(KIND_FIND, 500, 0);
        queue_req(KIND_SET, MAP_BITS - 1, 2047);
        queue_req(KIND_CLEAR, 60, 10);
        queue_req(KIND_FIND, 0, 0);
        queue_req(KIND_FIND, 65, 0);
        queue_req(KIND_FIND, 70, 0);
        queue_req(KIND_UNUSED, 5, 100);
        queue_req(KIND_UNUSED, MAP_BITS - 1, 2047);
        queue_req(KIND_FIND, 61, 0);
        queue_req(KIND_CLEAR, 128, 64);
        queue_req(KIND_FIND, 100, 0);
        queue_req(KIND_CLEAR, 0, 1);
        queue_req(KIND_FIND, 0, 0);
        drain();

        // search limit of zero, of one, above the map, and start at the limit
        cfg_write(LIMIT_ADDR, 11'd0);
        queue_req(KIND_FIND, 0, 0);
        drain();
        cfg_write(LIMIT_ADDR, 11'd1);
        queue_req(KIND_FIND, 0, 0);
        queue_req(KIND_FIND, 1, 0);
        drain();
        cfg_write(LIMIT_ADDR, 11'd2047);
        cfg_check(LIMIT_ADDR);
        queue_req(KIND_FIND, 200, 0);
        drain();
        cfg_write(LIMIT_ADDR, 11'd65);
        queue_req(KIND_FIND, 64, 0);
        queue_req(KIND_FIND, 65, 0);
        drain();

        // write to an address with no register must leave the limit alone
        cfg_write(SPARE_ADDR, 11'd3);
        cfg_check(LIMIT_ADDR);

        // random phases, each with its own limit and idle pattern
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            cfg_write(LIMIT_ADDR, phase_limit[ph]);
            cfg_check(LIMIT_ADDR);
            send_mode = idle_mode_t'(ph % 3);
            recv_mode = idle_mode_t'((ph + 1) % 3);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                pending_req_q.push_back(random_req());
                items_queued++;
            end
            if (ph == 0 || ph == 4)
                hold_requests++;
            drain();
        end

        if (predicted_rsp_q.size() != 0)
        begin
            $error("%0d result words never arrived", predicted_rsp_q.size());
            fail_count++;
        end
        $display("covered %0d requests: %0d set, %0d clear, %0d find (%0d hits), %0d unused",
                 items_accepted, n_set, n_clear, n_find, n_hit, n_unused);
        $display("search limit changed %0d times, two long response holds", n_limits);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

FILE: sim.f
src/brsc_pkg.sv
src/brsc_mem.sv
src/brsc_seq.sv
src/bitmap_range_set_clear_find_zero.sv
bench/tb_top.sv
